### hw/rtl/assert_macros.svh
// Concurrent assertion macros included by cube_map_face_uv.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons)

`define ASSERT_NEXT(label, clock, rst_n, ante, cons)

`endif

`endif

### hw/rtl/cmfu_pkg.sv
// Shared widths, face codes and types for the cube map face and UV block.
package cmfu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int SUM_W         = COORD_W + 1;
	localparam int OUT_FRAC      = 17;
	localparam int TEX_W         = OUT_FRAC + 1;
	localparam int FACE_W        = 3;
	localparam int S_DATA_W      = 3 * COORD_W;
	localparam int M_DATA_W      = ((2 * TEX_W + 7) / 8) * 8;

	localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [TEX_W-1:0] tex_t;

endpackage

### hw/rtl/cmfu_wrap.sv
// Reduce a face sum modulo 2.0 toward zero and halve it to a texture coordinate.
module cmfu_wrap #(
	parameter int FRAC_BITS = cmfu_pkg::FRAC_BITS_DEF
) (
	input  cmfu_pkg::sum_t sum,
	output cmfu_pkg::tex_t tex
);
	import cmfu_pkg::*;

	localparam int RW = FRAC_BITS + 1;

	logic          neg;
	logic [RW-1:0] low;
	logic [RW-1:0] mag;
	logic [OUT_FRAC-1:0] mag_scaled;

	assign neg = sum[SUM_W-1];
	assign low = sum[RW-1:0];
	assign mag = neg ? RW'(~low + RW'(1)) : low;

	generate
		if (RW <= OUT_FRAC) begin : g_up
			assign mag_scaled = OUT_FRAC'(mag) << (OUT_FRAC - RW);
		end else begin : g_down
			assign mag_scaled = OUT_FRAC'(mag >> (RW - OUT_FRAC));
		end
	endgenerate

	assign tex = neg ? -tex_t'({1'b0, mag_scaled}) : tex_t'({1'b0, mag_scaled});

endmodule

### hw/rtl/cube_map_face_uv.sv
// Cube map face selection with per-face wrapped texture coordinates, top level.
//
// Input stream s_*: one point per transfer, s_tdata = {z, y, x}, each a
// 32-bit signed value with FRAC_BITS fraction bits, x in the low bits.
// Output stream m_*: m_tuser carries the face (0 +x, 1 -x, 2 +y, 3 -y,
// 4 +z, 5 -z); m_tdata carries u in bits 17:0 and v in bits 35:18, each
// 18-bit signed with 17 fraction bits, upper bits zero.
// A point accepted on s_* passes the input register, then the result
// register, before it is presented on m_tvalid.
// Throughput: one point per cycle while m_tready is high; the face compare, face sums and the
// modulo-2 wrap all sit between the input register and the result register.
// Backpressure: while m_tready is low the result holds and one more point
// waits in the input register; s_tready drops only when both are full.
// Reset: arst_n clears both valid flags; no result is presented until a
// point has been accepted.
`include "assert_macros.svh"

module cube_map_face_uv #(
	parameter int FRAC_BITS = cmfu_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cmfu_pkg::S_DATA_W-1:0]  s_tdata,  // x_coord, y_coord, z_coord
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cmfu_pkg::M_DATA_W-1:0]  m_tdata,  // tex_u, tex_v, zero pad
	output logic [cmfu_pkg::FACE_W-1:0]    m_tuser   // face
);
	import cmfu_pkg::*;

	localparam sum_t ONE = sum_t'(1) << FRAC_BITS;
	localparam tex_t TEX_MOST_NEG = {1'b1, {(TEX_W-1){1'b0}}};

	logic                      vld_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic                      out_vld_q;
	logic [FACE_W-1:0]         face_q;
	tex_t                      u_q, v_q;

	logic                      adv_out;
	sum_t                      xe, ye, ze;
	logic [SUM_W-1:0]          ax, ay, az;
	logic [FACE_W-1:0]         face;
	sum_t                      su, sv;
	tex_t                      tex_u, tex_v;

	assign adv_out  = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1 <= s_tdata[COORD_W-1:0];
			y_s1 <= s_tdata[2*COORD_W-1:COORD_W];
			z_s1 <= s_tdata[3*COORD_W-1:2*COORD_W];
		end
	end

	assign xe = sum_t'(x_s1);
	assign ye = sum_t'(y_s1);
	assign ze = sum_t'(z_s1);
	assign ax = xe[SUM_W-1] ? -xe : xe;
	assign ay = ye[SUM_W-1] ? -ye : ye;
	assign az = ze[SUM_W-1] ? -ze : ze;

	always_comb begin
		if (ax >= ay && ax >= az) begin
			face = x_s1[COORD_W-1] ? FACE_NX : FACE_PX;
		end else if (ay >= az) begin
			face = y_s1[COORD_W-1] ? FACE_NY : FACE_PY;
		end else begin
			face = z_s1[COORD_W-1] ? FACE_NZ : FACE_PZ;
		end
	end

	always_comb begin
		case (face)
			FACE_PX: begin
				su = ONE - ze;
				sv = ye + ONE;
			end
			FACE_NX: begin
				su = ze + ONE;
				sv = ye + ONE;
			end
			FACE_PY: begin
				su = xe + ONE;
				sv = ONE - ze;
			end
			FACE_NY: begin
				su = xe + ONE;
				sv = ze + ONE;
			end
			FACE_PZ: begin
				su = xe + ONE;
				sv = ye + ONE;
			end
			default: begin
				su = ONE - xe;
				sv = ye + ONE;
			end
		endcase
	end

	cmfu_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_u (
		.sum (su),
		.tex (tex_u)
	);

	cmfu_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_v (
		.sum (sv),
		.tex (tex_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_out) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && vld_s1) begin
			face_q <= face;
			u_q    <= tex_u;
			v_q    <= tex_v;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = face_q;
	assign m_tdata  = M_DATA_W'({v_q, u_q});

	`ASSERT_NEXT(a_s1_moves_out, clk, arst_n, vld_s1 && adv_out, out_vld_q)
	`ASSERT_IMPLIES(a_blocked_full, clk, arst_n, !s_tready, vld_s1 && out_vld_q && !m_tready)
	`ASSERT_IMPLIES(a_tex_in_range, clk, arst_n, out_vld_q, u_q != TEX_MOST_NEG && v_q != TEX_MOST_NEG)

endmodule
